FILE: design/scd_pkg.sv
package scd_pkg;

   // default sweep length
   localparam int POSITIONS_DEFAULT = 32;

   // field widths
   localparam int READING_W  = 16;
   localparam int LIMIT_W    = 8;
   localparam int PWM_W      = 11;
   localparam int POS_OUT_W  = 5;
   localparam int PAN_OUT_W  = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // pan pulse limits
   localparam int PAN_MAX    = 2000;
   localparam int PAN_SAT_HI = 65535;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BREACH_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_PWM   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PWM     = 2'd3;

   // register reset values
   localparam logic [READING_W-1:0] THRESHOLD_RESET    = 16'd100;
   localparam logic [LIMIT_W-1:0]   BREACH_LIMIT_RESET = 8'd3;
   localparam logic [PWM_W-1:0]     CENTER_PWM_RESET   = 11'd1500;
   localparam logic [PWM_W-1:0]     STEP_PWM_RESET     = 11'd10;

   // transaction held in the compare stage
   typedef struct packed {
      logic valid;
      logic kind;
      logic cmp;
   } stage_type;

endpackage

FILE: design/scd_front.sv
module scd_front #(
   parameter int POSITIONS = scd_pkg::POSITIONS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [scd_pkg::READING_W-1:0]    req_reading,
   input  logic [scd_pkg::PWM_W-1:0]        step_pwm,
   input  logic                             advance,
   output scd_pkg::stage_type               stage,
   output logic [scd_pkg::READING_W-1:0]    stage_reading,
   output logic [scd_pkg::READING_W-1:0]    stage_prev,
   output logic [$clog2(POSITIONS)-1:0]     stage_pos,
   output logic [scd_pkg::PWM_W+$clog2(POSITIONS)-1:0] stage_prod
);

   localparam int POS_W  = $clog2(POSITIONS);
   localparam int PROD_W = scd_pkg::PWM_W + POS_W;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(POSITIONS - 1);

   logic [scd_pkg::READING_W-1:0] mem [POSITIONS];

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              refv_ff, refv_in;
   logic              accept;
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_kind_ff;
   logic              s1_cmp_ff;
   logic [scd_pkg::READING_W-1:0] s1_reading_ff;
   logic [scd_pkg::READING_W-1:0] s1_prev_ff;
   logic [POS_W-1:0]  s1_pos_ff;
   logic [PROD_W-1:0] s1_prod_ff;

   // stage is blocked only when the result register is full and held
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // sweep position runs ahead of detection; after a detection every reading
   // is ignored until a restart, which clears this state anyway
   always_comb begin
      pos_in  = pos_ff;
      refv_in = refv_ff;
      if (accept) begin
         if (req_kind) begin
            pos_in  = '0;
            refv_in = 1'b0;
         end else if (pos_ff == LAST_POS) begin
            pos_in  = '0;
            refv_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         refv_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         refv_ff     <= refv_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // reference store: read old value and write new reading in the same cycle;
   // two transactions at one position are a full sweep apart, so no forwarding
   always_ff @(posedge clock) begin
      if (accept && !req_kind) begin
         mem[pos_ff] <= req_reading;
      end
      if (accept) begin
         s1_prev_ff <= mem[pos_ff];
      end
   end

   // compare stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff    <= req_kind;
         s1_cmp_ff     <= refv_ff;
         s1_reading_ff <= req_reading;
         s1_pos_ff     <= pos_ff;
         s1_prod_ff    <= PROD_W'(step_pwm) * PROD_W'(pos_ff);
      end
   end

   assign stage.valid   = s1_valid_ff;
   assign stage.kind    = s1_kind_ff;
   assign stage.cmp     = s1_cmp_ff;
   assign stage_reading = s1_reading_ff;
   assign stage_prev    = s1_prev_ff;
   assign stage_pos     = s1_pos_ff;
   assign stage_prod    = s1_prod_ff;

endmodule

FILE: design/scd_eval.sv
module scd_eval #(
   parameter int POSITIONS = scd_pkg::POSITIONS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  scd_pkg::stage_type                   stage,
   input  logic [scd_pkg::READING_W-1:0]        stage_reading,
   input  logic [scd_pkg::READING_W-1:0]        stage_prev,
   input  logic [$clog2(POSITIONS)-1:0]         stage_pos,
   input  logic [scd_pkg::PWM_W+$clog2(POSITIONS)-1:0] stage_prod,
   input  logic [scd_pkg::READING_W-1:0]        threshold,
   input  logic [scd_pkg::LIMIT_W-1:0]          breach_limit,
   input  logic [scd_pkg::PWM_W-1:0]            center_pwm,
   input  logic [scd_pkg::PWM_W-1:0]            step_pwm,
   output logic                                 advance,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [scd_pkg::POS_OUT_W-1:0]        rsp_position,
   output logic signed [scd_pkg::PAN_OUT_W-1:0] rsp_pan_pwm,
   output logic                                 rsp_pan_out_of_range,
   output logic                                 rsp_compared,
   output logic [scd_pkg::READING_W-1:0]        rsp_difference,
   output logic [scd_pkg::LIMIT_W-1:0]          rsp_breach_run,
   output logic                                 rsp_detected,
   output logic                                 rsp_sweep_end
);

   localparam int POS_W  = $clog2(POSITIONS);
   localparam int SPAN_W = scd_pkg::PWM_W + $clog2(POSITIONS + 1);
   localparam int PAN_W  = (SPAN_W + 2 > 18) ? SPAN_W + 2 : 18;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(POSITIONS - 1);
   localparam logic signed [PAN_W-1:0] SAT_HI  = PAN_W'(scd_pkg::PAN_SAT_HI);
   localparam logic signed [PAN_W-1:0] SAT_LO  = -SAT_HI - PAN_W'(1);
   localparam logic signed [PAN_W-1:0] PAN_TOP = PAN_W'(scd_pkg::PAN_MAX);
   localparam logic [scd_pkg::LIMIT_W-1:0] RUN_MAX = '1;

   logic [SPAN_W-1:0]  half_span;
   logic signed [PAN_W-1:0] pan, pan_sat;
   logic [scd_pkg::READING_W-1:0] diff_abs;
   logic [scd_pkg::LIMIT_W-1:0]   run_inc;
   logic               out_free;
   logic               last;

   logic [scd_pkg::LIMIT_W-1:0] breach_ff, breach_in;
   logic                        detect_ff, detect_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [scd_pkg::POS_OUT_W-1:0]        rsp_position_ff, rsp_position_in;
   logic signed [scd_pkg::PAN_OUT_W-1:0] rsp_pan_pwm_ff, rsp_pan_pwm_in;
   logic                                 rsp_range_ff, rsp_range_in;
   logic                                 rsp_compared_ff, rsp_compared_in;
   logic [scd_pkg::READING_W-1:0]        rsp_diff_ff, rsp_diff_in;
   logic [scd_pkg::LIMIT_W-1:0]          rsp_run_ff, rsp_run_in;
   logic                                 rsp_detected_ff, rsp_detected_in;
   logic                                 rsp_end_ff, rsp_end_in;

   // result register frees up when empty or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = stage.valid && out_free;

   // pan pulse: center + step * pos - floor(step * positions / 2)
   assign half_span = (SPAN_W'(step_pwm) * SPAN_W'(POSITIONS)) >> 1;
   assign pan = $signed(PAN_W'(center_pwm)) + $signed(PAN_W'(stage_prod))
              - $signed(PAN_W'(half_span));

   always_comb begin
      if (pan > SAT_HI) begin
         pan_sat = SAT_HI;
      end else if (pan < SAT_LO) begin
         pan_sat = SAT_LO;
      end else begin
         pan_sat = pan;
      end
   end

   // absolute difference and saturating run increment
   assign diff_abs = (stage_reading >= stage_prev) ? stage_reading - stage_prev
                                                   : stage_prev - stage_reading;
   assign run_inc  = (breach_ff == RUN_MAX) ? breach_ff
                                            : breach_ff + scd_pkg::LIMIT_W'(1);
   assign last     = (stage_pos == LAST_POS);

   // compare, breach run and detection latch
   always_comb begin
      breach_in       = breach_ff;
      detect_in       = detect_ff;
      rsp_position_in = '0;
      rsp_pan_pwm_in  = '0;
      rsp_range_in    = 1'b0;
      rsp_compared_in = 1'b0;
      rsp_diff_in     = '0;
      rsp_run_in      = '0;
      rsp_detected_in = 1'b0;
      rsp_end_in      = 1'b0;
      if (stage.kind) begin
         // restart
         breach_in = '0;
         detect_in = 1'b0;
      end else if (detect_ff) begin
         // ignored after detection
         rsp_run_in      = breach_ff;
         rsp_detected_in = 1'b1;
      end else begin
         if (stage.cmp) begin
            rsp_diff_in = diff_abs;
            breach_in   = (diff_abs > threshold) ? run_inc : '0;
         end
         detect_in       = (breach_in >= breach_limit);
         rsp_position_in = scd_pkg::POS_OUT_W'(stage_pos);
         rsp_pan_pwm_in  = scd_pkg::PAN_OUT_W'(pan_sat);
         rsp_range_in    = (pan < $signed(PAN_W'(0))) || (pan > PAN_TOP);
         rsp_compared_in = stage.cmp;
         rsp_run_in      = breach_in;
         rsp_detected_in = detect_in;
         rsp_end_in      = last;
         // an undetected run restarts with every sweep
         if (!detect_in && last) begin
            breach_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         breach_ff    <= '0;
         detect_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            breach_ff <= breach_in;
            detect_ff <= detect_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_position_ff <= rsp_position_in;
         rsp_pan_pwm_ff  <= rsp_pan_pwm_in;
         rsp_range_ff    <= rsp_range_in;
         rsp_compared_ff <= rsp_compared_in;
         rsp_diff_ff     <= rsp_diff_in;
         rsp_run_ff      <= rsp_run_in;
         rsp_detected_ff <= rsp_detected_in;
         rsp_end_ff      <= rsp_end_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_position         = rsp_position_ff;
   assign rsp_pan_pwm          = rsp_pan_pwm_ff;
   assign rsp_pan_out_of_range = rsp_range_ff;
   assign rsp_compared         = rsp_compared_ff;
   assign rsp_difference       = rsp_diff_ff;
   assign rsp_breach_run       = rsp_run_ff;
   assign rsp_detected         = rsp_detected_ff;
   assign rsp_sweep_end        = rsp_end_ff;

endmodule

FILE: design/scan_change_detector_top.sv
// channel   | ports                                     | direction
// ----------+-------------------------------------------+----------
// request   | req_valid, req_stall, req_kind, req_reading | in
// response  | rsp_valid, rsp_stall, rsp_position .. rsp_sweep_end | out
// csr       | csr_write, csr_index, csr_data            | in
//
// one transaction per cycle sustained while rsp_stall is low; from request
// accept to response valid it passes the reference store read, then the compare stage
// the single-port reference store read and write at accept set the rate
// reset is synchronous and clears counters, flags, valids and configuration registers;
// the reference store is not cleared, a sweep is stored before it is read
// response stall holds the result register and backs up into req_stall
module scan_change_detector_top #(
   parameter int POSITIONS = scd_pkg::POSITIONS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [scd_pkg::READING_W-1:0]        req_reading,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [scd_pkg::POS_OUT_W-1:0]        rsp_position,
   output logic signed [scd_pkg::PAN_OUT_W-1:0] rsp_pan_pwm,
   output logic                                 rsp_pan_out_of_range,
   output logic                                 rsp_compared,
   output logic [scd_pkg::READING_W-1:0]        rsp_difference,
   output logic [scd_pkg::LIMIT_W-1:0]          rsp_breach_run,
   output logic                                 rsp_detected,
   output logic                                 rsp_sweep_end,
   input  logic                                 csr_write,
   input  logic [scd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [scd_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int POS_W  = $clog2(POSITIONS);
   localparam int PROD_W = scd_pkg::PWM_W + POS_W;

   logic [scd_pkg::READING_W-1:0] threshold_ff;
   logic [scd_pkg::LIMIT_W-1:0]   breach_limit_ff;
   logic [scd_pkg::PWM_W-1:0]     center_pwm_ff;
   logic [scd_pkg::PWM_W-1:0]     step_pwm_ff;

   scd_pkg::stage_type            stage;
   logic [scd_pkg::READING_W-1:0] stage_reading;
   logic [scd_pkg::READING_W-1:0] stage_prev;
   logic [POS_W-1:0]              stage_pos;
   logic [PROD_W-1:0]             stage_prod;
   logic                          advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= scd_pkg::THRESHOLD_RESET;
         breach_limit_ff <= scd_pkg::BREACH_LIMIT_RESET;
         center_pwm_ff   <= scd_pkg::CENTER_PWM_RESET;
         step_pwm_ff     <= scd_pkg::STEP_PWM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            scd_pkg::CSR_THRESHOLD: begin
               threshold_ff <= csr_data;
            end
            scd_pkg::CSR_BREACH_LIMIT: begin
               breach_limit_ff <= csr_data[scd_pkg::LIMIT_W-1:0];
            end
            scd_pkg::CSR_CENTER_PWM: begin
               center_pwm_ff <= csr_data[scd_pkg::PWM_W-1:0];
            end
            scd_pkg::CSR_STEP_PWM: begin
               step_pwm_ff <= csr_data[scd_pkg::PWM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // position tracking and reference store
   scd_front #(
      .POSITIONS (POSITIONS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_reading   (req_reading),
      .step_pwm      (step_pwm_ff),
      .advance       (advance),
      .stage         (stage),
      .stage_reading (stage_reading),
      .stage_prev    (stage_prev),
      .stage_pos     (stage_pos),
      .stage_prod    (stage_prod)
   );

   // compare, detection and result register
   scd_eval #(
      .POSITIONS (POSITIONS)
   ) u_eval (
      .clock                (clock),
      .reset                (reset),
      .stage                (stage),
      .stage_reading        (stage_reading),
      .stage_prev           (stage_prev),
      .stage_pos            (stage_pos),
      .stage_prod           (stage_prod),
      .threshold            (threshold_ff),
      .breach_limit         (breach_limit_ff),
      .center_pwm           (center_pwm_ff),
      .step_pwm             (step_pwm_ff),
      .advance              (advance),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_position         (rsp_position),
      .rsp_pan_pwm          (rsp_pan_pwm),
      .rsp_pan_out_of_range (rsp_pan_out_of_range),
      .rsp_compared         (rsp_compared),
      .rsp_difference       (rsp_difference),
      .rsp_breach_run       (rsp_breach_run),
      .rsp_detected         (rsp_detected),
      .rsp_sweep_end        (rsp_sweep_end)
   );

   // request side only backs up behind a held response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while response register free");

   // an undetected nonzero run stays below the limit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_detected && (rsp_breach_run != '0))
         |-> (rsp_breach_run < breach_limit_ff))
      else $error("breach run reached limit without detection");

   // sweep end only on the last position
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sweep_end)
         |-> (rsp_position == scd_pkg::POS_OUT_W'(POSITIONS - 1)))
      else $error("sweep end on wrong position");

   // a reading shows a difference only when compared
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_compared) |-> (rsp_difference == '0))
      else $error("difference reported without a reference");

endmodule
